// ----- hw/rtl/hled_pkg.sv -----
// ----------------------------------------------------------------------------
// hled_pkg
// Shared types and register indexes for the hysteresis lift event detector.
// ----------------------------------------------------------------------------
package hled_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int TIME_W      = 32;
    localparam int DIST_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_AIR_TIME    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRACTORY_TIME = 2'd3;

    localparam logic [DIST_W-1:0] CLOSE_THRESHOLD_RST = 16'd50;
    localparam logic [DIST_W-1:0] FAR_THRESHOLD_RST   = 16'd100;
    localparam logic [TIME_W-1:0] MIN_AIR_TIME_RST    = 32'd100;
    localparam logic [TIME_W-1:0] REFRACTORY_TIME_RST = 32'd200;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [DIST_W-1:0] distance_mm;
        logic              last_sample;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] event_start_ms;
        logic [TIME_W-1:0] event_end_ms;
        logic [DIST_W-1:0] peak_mm;
    } out_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] close_threshold;
        logic [DIST_W-1:0] far_threshold;
        logic [TIME_W-1:0] min_air_time;
        logic [TIME_W-1:0] refractory_time;
    } cfg_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

endpackage

// ----- hw/rtl/hled_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hled_cfg_regs
// Threshold and timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module hled_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [hled_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hled_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output hled_pkg::cfg_t                   cfg
);

    hled_pkg::cfg_t cfg_reg;
    hled_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                hled_pkg::REG_CLOSE_THRESHOLD: begin
                    cfg_next.close_threshold = cfg_wdata[hled_pkg::DIST_W-1:0];
                end
                hled_pkg::REG_FAR_THRESHOLD: begin
                    cfg_next.far_threshold = cfg_wdata[hled_pkg::DIST_W-1:0];
                end
                hled_pkg::REG_MIN_AIR_TIME: begin
                    cfg_next.min_air_time = cfg_wdata[hled_pkg::TIME_W-1:0];
                end
                hled_pkg::REG_REFRACTORY_TIME: begin
                    cfg_next.refractory_time = cfg_wdata[hled_pkg::TIME_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.close_threshold <= hled_pkg::CLOSE_THRESHOLD_RST;
            cfg_reg.far_threshold   <= hled_pkg::FAR_THRESHOLD_RST;
            cfg_reg.min_air_time    <= hled_pkg::MIN_AIR_TIME_RST;
            cfg_reg.refractory_time <= hled_pkg::REFRACTORY_TIME_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/hled_in_stage.sv -----
// ----------------------------------------------------------------------------
// hled_in_stage
// Input register: captures one sample and holds it until the detector
// takes it.
// ----------------------------------------------------------------------------
module hled_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hled_pkg::in_item_t s_data,
    input  logic               advance,
    output hled_pkg::stage_t   stage
);

    logic               valid_reg;
    logic               valid_next;
    hled_pkg::in_item_t item_reg;
    hled_pkg::in_item_t item_next;
    logic               take;

    assign s_ready = aresetn && (!valid_reg || advance);
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next = 1'b1;
            item_next  = s_data;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ----- hw/rtl/hled_detect.sv -----
// ----------------------------------------------------------------------------
// hled_detect
// Event state and result register: opens, tracks and closes lift events
// and holds a reported event until it is transferred.
// ----------------------------------------------------------------------------
module hled_detect (
    input  logic                aclk,
    input  logic                aresetn,
    input  hled_pkg::cfg_t      cfg,
    input  hled_pkg::stage_t    stage,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output hled_pkg::out_item_t m_data
);

    logic                          in_event_reg;
    logic                          in_event_next;
    logic [hled_pkg::TIME_W-1:0]   start_reg;
    logic [hled_pkg::TIME_W-1:0]   start_next;
    logic [hled_pkg::DIST_W-1:0]   peak_reg;
    logic [hled_pkg::DIST_W-1:0]   peak_next;
    logic [hled_pkg::TIME_W-1:0]   last_end_reg;
    logic [hled_pkg::TIME_W-1:0]   last_end_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    hled_pkg::out_item_t           out_reg;
    hled_pkg::out_item_t           out_next;

    logic [hled_pkg::TIME_W-1:0]   t;
    logic [hled_pkg::DIST_W-1:0]   d;
    logic [hled_pkg::TIME_W-1:0]   since_end;
    logic [hled_pkg::TIME_W-1:0]   duration;
    logic [hled_pkg::TIME_W-1:0]   start_eff;
    logic [hled_pkg::DIST_W-1:0]   peak_eff;
    logic                          open_ok;
    logic                          event_eff;
    logic                          close_now;
    logic                          report;

    assign advance = stage.valid && (!out_valid_reg || m_ready);

    always_comb begin
        t         = stage.item.time_ms;
        d         = stage.item.distance_mm;
        since_end = t - last_end_reg;
        open_ok   = (d >= cfg.far_threshold) && (since_end >= cfg.refractory_time);
        event_eff = in_event_reg || open_ok;
        start_eff = in_event_reg ? start_reg : t;
        if (in_event_reg) begin
            peak_eff = (d > peak_reg) ? d : peak_reg;
        end else begin
            peak_eff = d;
        end
        close_now = event_eff &&
                    (stage.item.last_sample || (in_event_reg && d <= cfg.close_threshold));
        duration  = t - start_eff;
        report    = close_now && (duration >= cfg.min_air_time);

        in_event_next  = in_event_reg;
        start_next     = start_reg;
        peak_next      = peak_reg;
        last_end_next  = last_end_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance) begin
            out_valid_next = report;
            if (report) begin
                out_next.event_start_ms = start_eff;
                out_next.event_end_ms   = t;
                out_next.peak_mm        = peak_eff;
            end
            if (stage.item.last_sample) begin
                in_event_next = 1'b0;
                start_next    = '0;
                peak_next     = '0;
                last_end_next = '0;
            end else begin
                in_event_next = event_eff && !close_now;
                start_next    = start_eff;
                peak_next     = close_now ? '0 : peak_eff;
                if (report) begin
                    last_end_next = t;
                end
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_event_reg  <= 1'b0;
            start_reg     <= '0;
            peak_reg      <= '0;
            last_end_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_event_reg  <= in_event_next;
            start_reg     <= start_next;
            peak_reg      <= peak_next;
            last_end_reg  <= last_end_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- hw/rtl/hysteresis_lift_event_detector.sv -----
// ----------------------------------------------------------------------------
// hysteresis_lift_event_detector
// Detects lift events in a stream of timestamped distance samples.
//
// Samples enter on the s_ channel (valid/ready); each reported event leaves
// on the m_ channel as start time, end time and peak distance. A sample
// gives zero or one result. A sample is registered on transfer, evaluated
// against the event state while it is held in the input register and, if it
// closes a long enough event, shown on m_ in the cycle after it advances.
// One sample per cycle is sustained while no result is held by m_ready low;
// the event state is updated directly from the registered sample.
// When m_ready is low with a result held, the detector keeps evaluating
// nothing new; the input register still takes one sample, then s_ready
// drops until the result is transferred.
// Reset clears the event state, empties both registers and loads the default
// thresholds and times. A sample marked last closes any open event and returns
// the event state to reset values; the registers keep theirs. The user must
// write registers only while idle (cfg_we/cfg_index/cfg_wdata); not enforced.
// ----------------------------------------------------------------------------
module hysteresis_lift_event_detector (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hled_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hled_pkg::out_item_t              m_data,
    input  logic                             cfg_we,
    input  logic [hled_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hled_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    hled_pkg::cfg_t   cfg;
    hled_pkg::stage_t stage;
    logic             advance;

    hled_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hled_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .advance (advance),
        .stage   (stage)
    );

    hled_detect u_detect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .stage   (stage),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hw/rtl/hled_checker.sv -----
// ----------------------------------------------------------------------------
// hled_checker
// Port-level checks for the hysteresis lift event detector.
// ----------------------------------------------------------------------------
module hled_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input hled_pkg::out_item_t m_data
);

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_ready_in_reset : assert property (@(posedge aclk)
        !aresetn |-> !s_ready)
        else $error("sample transfer possible during reset");

    a_result_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("held result dropped or changed");

    a_result_latency : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a sample two cycles before");

endmodule

bind hysteresis_lift_event_detector hled_checker u_hled_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
